// ===== rtl/core/tdmm_pkg.sv =====
// ============================================================================
// Tridiagonal matrix multiply package
// Shared constants, register indexes, multiplier slots and the result tag.
// ============================================================================
package tdmm_pkg;

    localparam int MAX_COLS_DEF  = 256;
    localparam int DATA_BITS_DEF = 16;

    localparam int ROW_W      = 16;
    localparam int COL_W      = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_ROWS_W = 16;
    localparam int CFG_COLS_W = 9;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

    // Multiplier slots. The first three sum into the held row's result, the
    // last two into the final row's result.
    localparam int NUM_MUL        = 5;
    localparam int MUL_DIAG       = 0;
    localparam int MUL_UPPER      = 1;
    localparam int MUL_LOWER      = 2;
    localparam int MUL_LAST_LOWER = 3;
    localparam int MUL_LAST_DIAG  = 4;

    // Bookkeeping that travels with each request through the pipeline.
    typedef struct packed {
        logic             has_a;   // first result exists
        logic             has_b;   // second result exists
        logic             last_a;  // matrix_last of the first result
        logic             last_b;  // matrix_last of the second result
        logic             run_a;   // run_last of the first result
        logic [ROW_W-1:0] row_a;   // row of the first result
        logic [COL_W-1:0] col;     // column of both results
    } t_tag;

endpackage

// ===== rtl/core/tdmm_ifs.sv =====
// ============================================================================
// Tridiagonal matrix multiply channels
// Valid/ready request and result channels with their payloads.
// ============================================================================
interface tdmm_in_if import tdmm_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [DATA_BITS-1:0] rhs_value;
    logic signed [DATA_BITS-1:0] upper_coef;
    logic signed [DATA_BITS-1:0] diag_coef;
    logic signed [DATA_BITS-1:0] lower_coef;

    modport source (output valid, output rhs_value, output upper_coef,
                    output diag_coef, output lower_coef, input ready);
    modport sink   (input valid, input rhs_value, input upper_coef,
                    input diag_coef, input lower_coef, output ready);
endinterface

interface tdmm_out_if import tdmm_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [2*DATA_BITS:0]     out_value;
    logic        [ROW_W-1:0]         out_row;
    logic        [COL_W-1:0]         out_col;
    logic                            matrix_last;
    logic                            run_last;

    modport source (output valid, output out_value, output out_row,
                    output out_col, output matrix_last, output run_last,
                    input ready);
    modport sink   (input valid, input out_value, input out_row,
                    input out_col, input matrix_last, input run_last,
                    output ready);
endinterface

// ===== rtl/core/tdmm_seq.sv =====
// ============================================================================
// Tridiagonal matrix multiply sequencer
// Position counters, held coefficients, row buffers and the first stage.
// ============================================================================
module tdmm_seq import tdmm_pkg::*; #(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    tdmm_in_if.sink                     i_req,
    output logic                        o_s1_valid,
    input  logic                        i_s1_ready,
    output logic signed [DATA_BITS-1:0] o_opa [NUM_MUL],
    output logic signed [DATA_BITS-1:0] o_opb [NUM_MUL],
    output t_tag                        o_s1_tag
);

    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int NW = ($clog2(MAX_COLS + 1) > CFG_COLS_W) ?
                        $clog2(MAX_COLS + 1) : CFG_COLS_W;

    logic [CFG_ROWS_W-1:0]       r_rows;
    logic [CFG_COLS_W-1:0]       r_cols;
    logic [CW-1:0]               r_col;
    logic [ROW_W-1:0]            r_row;
    logic signed [DATA_BITS-1:0] r_hu, r_hd, r_hl;
    logic                        r_clr_busy;
    logic [CW-1:0]               r_clr_addr;

    logic signed [DATA_BITS-1:0] r_held_mem  [MAX_COLS];
    logic signed [DATA_BITS-1:0] r_older_mem [MAX_COLS];

    logic                        r_s1_v;
    logic signed [DATA_BITS-1:0] r_s1_r, r_s1_dg, r_s1_lo;
    logic signed [DATA_BITS-1:0] r_s1_hu, r_s1_hd, r_s1_hl;
    logic signed [DATA_BITS-1:0] r_s1_hr, r_s1_or;
    logic [CW-1:0]               r_s1_c;
    logic                        r_s1_row0, r_s1_ge2;
    t_tag                        r_s1_tag;

    logic [NW-1:0]         cols_eff, col_lim;
    logic [CFG_ROWS_W-1:0] rows_eff, row_lim;
    logic                  col_last, row_last, row0;
    logic                  s1_free, s1_adv, in_fire, fwd;
    logic                  mem_we;
    logic [CW-1:0]         mem_wa;
    t_tag                  n_tag;

    always_comb begin
        cols_eff = (r_cols == '0) ? NW'(1) : NW'(r_cols);
        if (cols_eff > NW'(MAX_COLS)) begin
            cols_eff = NW'(MAX_COLS);
        end
        col_lim  = cols_eff - NW'(1);
        rows_eff = (r_rows == '0) ? CFG_ROWS_W'(1) : r_rows;
        row_lim  = rows_eff - CFG_ROWS_W'(1);
    end

    assign col_last = NW'(r_col) >= col_lim;
    assign row_last = r_row >= row_lim;
    assign row0     = r_row == '0;

    assign s1_free     = !r_s1_v || i_s1_ready;
    assign s1_adv      = r_s1_v && i_s1_ready;
    assign i_req.ready = !r_clr_busy && s1_free;
    assign in_fire     = i_req.valid && i_req.ready;
    // The request in stage one writes the same column as it leaves.
    assign fwd         = r_s1_v && (r_s1_c == r_col);

    assign mem_we = r_clr_busy || s1_adv;
    assign mem_wa = r_clr_busy ? r_clr_addr : r_s1_c;

    always_comb begin
        n_tag.has_a  = !row0 || row_last;
        n_tag.has_b  = !row0 && row_last;
        n_tag.last_a = row0 && col_last;
        n_tag.last_b = col_last;
        n_tag.run_a  = row0 || !row_last;
        n_tag.row_a  = row0 ? '0 : r_row - ROW_W'(1);
        n_tag.col    = COL_W'(r_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= CFG_ROWS_W'(1);
            r_cols     <= CFG_COLS_W'(1);
            r_col      <= '0;
            r_row      <= '0;
            r_hu       <= '0;
            r_hd       <= '0;
            r_hl       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: r_rows <= i_cfg_data;
                    REG_COLS: r_cols <= i_cfg_data[CFG_COLS_W-1:0];
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                if (r_clr_addr == CW'(MAX_COLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + CW'(1);
            end
            if (in_fire) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ROW_W'(1);
                    r_hu  <= i_req.upper_coef;
                    r_hd  <= i_req.diag_coef;
                    r_hl  <= i_req.lower_coef;
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (s1_free) begin
                r_s1_v <= in_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_held_mem[mem_wa]  <= r_clr_busy ? '0 : r_s1_r;
            r_older_mem[mem_wa] <= r_clr_busy ? '0 : r_s1_hr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_r    <= i_req.rhs_value;
            r_s1_dg   <= i_req.diag_coef;
            r_s1_lo   <= i_req.lower_coef;
            r_s1_hu   <= r_hu;
            r_s1_hd   <= r_hd;
            r_s1_hl   <= r_hl;
            r_s1_hr   <= fwd ? r_s1_r  : r_held_mem[r_col];
            r_s1_or   <= fwd ? r_s1_hr : r_older_mem[r_col];
            r_s1_c    <= r_col;
            r_s1_row0 <= row0;
            r_s1_ge2  <= r_row >= ROW_W'(2);
            r_s1_tag  <= n_tag;
        end
    end

    // On the first row only the diagonal product of the new element counts.
    always_comb begin
        o_opa[MUL_DIAG]       = r_s1_row0 ? r_s1_dg : r_s1_hd;
        o_opb[MUL_DIAG]       = r_s1_row0 ? r_s1_r  : r_s1_hr;
        o_opa[MUL_UPPER]      = r_s1_row0 ? '0 : r_s1_hu;
        o_opb[MUL_UPPER]      = r_s1_r;
        o_opa[MUL_LOWER]      = r_s1_ge2 ? r_s1_hl : '0;
        o_opb[MUL_LOWER]      = r_s1_or;
        o_opa[MUL_LAST_LOWER] = r_s1_lo;
        o_opb[MUL_LAST_LOWER] = r_s1_hr;
        o_opa[MUL_LAST_DIAG]  = r_s1_dg;
        o_opb[MUL_LAST_DIAG]  = r_s1_r;
    end

    assign o_s1_valid = r_s1_v;
    assign o_s1_tag   = r_s1_tag;

endmodule

// ===== rtl/core/tdmm_mac.sv =====
// ============================================================================
// Tridiagonal matrix multiply arithmetic
// Product stage and sum stage of the pipeline.
// ============================================================================
module tdmm_mac import tdmm_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [DATA_BITS-1:0] i_opa [NUM_MUL],
    input  logic signed [DATA_BITS-1:0] i_opb [NUM_MUL],
    input  t_tag                        i_tag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [2*DATA_BITS:0] o_sum_a,
    output logic signed [2*DATA_BITS:0] o_sum_b,
    output t_tag                        o_tag
);

    localparam int PW = 2 * DATA_BITS;
    localparam int OW = PW + 1;

    logic                 r_s2_v, r_s3_v;
    logic signed [PW-1:0] r_p [NUM_MUL];
    t_tag                 r_s2_tag, r_s3_tag;
    logic signed [OW-1:0] r_sa, r_sb;
    logic                 s2_free, s3_free;

    assign s3_free = !r_s3_v || i_ready;
    assign s2_free = !r_s2_v || s3_free;
    assign o_ready = s2_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s2_free) begin
                r_s2_v <= i_valid;
            end
            if (s3_free) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_valid) begin
            for (int k = 0; k < NUM_MUL; k++) begin
                r_p[k] <= i_opa[k] * i_opb[k];
            end
            r_s2_tag <= i_tag;
        end
        if (s3_free && r_s2_v) begin
            r_sa     <= OW'(r_p[MUL_DIAG]) + OW'(r_p[MUL_UPPER]) + OW'(r_p[MUL_LOWER]);
            r_sb     <= OW'(r_p[MUL_LAST_LOWER]) + OW'(r_p[MUL_LAST_DIAG]);
            r_s3_tag <= r_s2_tag;
        end
    end

    assign o_valid = r_s3_v;
    assign o_sum_a = r_sa;
    assign o_sum_b = r_sb;
    assign o_tag   = r_s3_tag;

endmodule

// ===== rtl/core/tdmm_out.sv =====
// ============================================================================
// Tridiagonal matrix multiply result register
// Holds one request's results and hands them out one at a time.
// ============================================================================
module tdmm_out import tdmm_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [2*DATA_BITS:0] i_sum_a,
    input  logic signed [2*DATA_BITS:0] i_sum_b,
    input  t_tag                        i_tag,
    tdmm_out_if.source                  o_rsp
);

    logic                        r_v, r_sel;
    logic signed [2*DATA_BITS:0] r_a, r_b;
    t_tag                        r_tag;
    logic                        last_shown, free;

    assign last_shown = r_sel || !r_tag.has_b;
    assign free       = !r_v || (o_rsp.ready && last_shown);
    assign o_ready    = free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v   <= 1'b0;
            r_sel <= 1'b0;
        end else if (i_valid && free) begin
            // A request without results passes through and is dropped here.
            r_v   <= i_tag.has_a;
            r_sel <= 1'b0;
        end else if (r_v && o_rsp.ready) begin
            if (last_shown) begin
                r_v <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && free) begin
            r_a   <= i_sum_a;
            r_b   <= i_sum_b;
            r_tag <= i_tag;
        end
    end

    assign o_rsp.valid       = r_v;
    assign o_rsp.out_value   = r_sel ? r_b : r_a;
    assign o_rsp.out_row     = r_sel ? r_tag.row_a + ROW_W'(1) : r_tag.row_a;
    assign o_rsp.out_col     = r_tag.col;
    assign o_rsp.matrix_last = r_sel ? r_tag.last_b : r_tag.last_a;
    assign o_rsp.run_last    = r_sel || r_tag.run_a;

endmodule

// ===== rtl/core/tridiagonal_matrix_multiply_stream.sv =====
// ============================================================================
// Tridiagonal matrix multiply, streaming
// Computes y = T * R for a tridiagonal T and a row-major stream of R.
// ============================================================================
//
//  Channel  Direction  Handshake      Carries
//  -------  ---------  -------------  ------------------------------------------
//  i_req    in         valid / ready  rhs_value, upper/diag/lower coefficients
//  o_rsp    out        valid / ready  out_value, out_row, out_col, flags
//  i_cfg_*  in         write enable   rows_in_use (0), columns_in_use (1)
//
//  One request is taken per cycle while i_req.ready is high. A request on the
//  last row of a matrix produces two results, which the result register hands
//  out in turn. A request passes the row buffer read, the five multipliers,
//  the sums and the result register before its first result. After reset
//  the row buffers are cleared one column per cycle, and i_req.ready stays
//  low until all are cleared; configuration writes are taken meanwhile.
//  A stall at o_rsp backs up through the stages and drops nothing.
//
// Each element r[j][k] is stored in a row buffer; the row before is moved to
// a second buffer at the same time. While row j+1 streams in, row j's result
// y[j][k] is formed from the held coefficients of row j, the two buffered
// elements and the new element. The coefficients of a row are latched from
// its last element.
module tridiagonal_matrix_multiply_stream import tdmm_pkg::*; #(
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tdmm_in_if.sink              i_req,
    tdmm_out_if.source           o_rsp
);

    logic                        s1_valid, s1_ready;
    logic signed [DATA_BITS-1:0] opa [NUM_MUL];
    logic signed [DATA_BITS-1:0] opb [NUM_MUL];
    t_tag                        s1_tag;

    logic                        s3_valid, s3_ready;
    logic signed [2*DATA_BITS:0] sum_a, sum_b;
    t_tag                        s3_tag;

    // Counters, coefficient latches, row buffers and the first stage.
    tdmm_seq #(
        .MAX_COLS  (MAX_COLS),
        .DATA_BITS (DATA_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_req),
        .o_s1_valid (s1_valid),
        .i_s1_ready (s1_ready),
        .o_opa      (opa),
        .o_opb      (opb),
        .o_s1_tag   (s1_tag)
    );

    // Products, then the two sums of the held row and of the last row.
    tdmm_mac #(
        .DATA_BITS (DATA_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_opa   (opa),
        .i_opb   (opb),
        .i_tag   (s1_tag),
        .o_valid (s3_valid),
        .i_ready (s3_ready),
        .o_sum_a (sum_a),
        .o_sum_b (sum_b),
        .o_tag   (s3_tag)
    );

    // Result register that splits a two-result request into two transfers.
    tdmm_out #(
        .DATA_BITS (DATA_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_sum_a (sum_a),
        .i_sum_b (sum_b),
        .i_tag   (s3_tag),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== rtl/core/tdmm_chk.sv =====
// ============================================================================
// Tridiagonal matrix multiply port checker
// Watches the top level's channels and flags broken result sequences.
// ============================================================================
module tdmm_chk import tdmm_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic signed [2*DATA_BITS:0] i_out_value,
    input logic [ROW_W-1:0]            i_out_row,
    input logic [COL_W-1:0]            i_out_col,
    input logic                        i_matrix_last,
    input logic                        i_run_last
);

    // Reset empties the result register.
    a_rst_out_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // Reset starts the row buffer clearing pass, which holds off requests.
    a_rst_in_hold: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("request taken during row buffer clearing");

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value) &&
            $stable(i_out_row) && $stable(i_out_col))
        else $error("stalled result changed");

    // The first of a result pair is followed at once by the next row's
    // result in the same column.
    a_pair_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_run_last |=> i_out_valid &&
            (i_out_row == ROW_W'($past(i_out_row) + ROW_W'(1))) &&
            (i_out_col == $past(i_out_col)))
        else $error("second result of a pair missing or misplaced");

    // The final element of a matrix always closes its request.
    a_mlast_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_matrix_last |-> i_run_last)
        else $error("matrix_last on a result that is not the request's last");

endmodule

bind tridiagonal_matrix_multiply_stream tdmm_chk #(
    .DATA_BITS (DATA_BITS)
) u_tdmm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_req.ready),
    .i_out_valid   (o_rsp.valid),
    .i_out_ready   (o_rsp.ready),
    .i_out_value   (o_rsp.out_value),
    .i_out_row     (o_rsp.out_row),
    .i_out_col     (o_rsp.out_col),
    .i_matrix_last (o_rsp.matrix_last),
    .i_run_last    (o_rsp.run_last)
);

// ===== bench/tridiagonal_product_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tridiagonal product checker
// Watches the register port and both channels, keeps its own copy of the
// row buffers and counters, works out y = T * R for every accepted request
// and compares each accepted result with the oldest outstanding product.
// ============================================================================
module tridiagonal_product_checker import tdmm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    tdmm_in_if                   i_req,
    tdmm_out_if                  o_rsp,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    typedef struct packed {
        logic signed [32:0] value;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               mlast;
        logic               rlast;
    } t_product;

    t_product products[$];

    logic [CFG_ROWS_W-1:0] rows_cfg;
    logic [CFG_COLS_W-1:0] cols_cfg;
    logic signed [15:0]    older_row [MAX_COLS_DEF];
    logic signed [15:0]    held_row  [MAX_COLS_DEF];
    logic signed [15:0]    held_upper;
    logic signed [15:0]    held_diag;
    logic signed [15:0]    held_lower;
    int                    col_count;
    int                    row_count;
    int                    fails;
    int                    checked;

    function automatic longint mul(input logic signed [15:0] a, input logic signed [15:0] b);
        return longint'(a) * longint'(b);
    endfunction

    function automatic string describe(input t_product p);
        return $sformatf("value=%0d row=%0d col=%0d mlast=%0b rlast=%0b",
                         p.value, p.row, p.col, p.mlast, p.rlast);
    endfunction

    function automatic void queue_product(input longint value, input int row, input int col,
                                          input bit mlast, input bit rlast);
        t_product p;
        p.value = value[32:0];
        p.row   = row[ROW_W-1:0];
        p.col   = col[COL_W-1:0];
        p.mlast = mlast;
        p.rlast = rlast;
        products.push_back(p);
    endfunction

    // One request: emit the held row's result (and the final row's result on
    // the last row), then shift the new element into the row buffers.
    function automatic void predict_products(input logic signed [15:0] rhs,
                                             input logic signed [15:0] up,
                                             input logic signed [15:0] dg,
                                             input logic signed [15:0] lo);
        int     m;
        int     n;
        int     c;
        bit     col_last;
        bit     row_last;
        longint acc;
        m = (rows_cfg == 0) ? 1 : int'(rows_cfg);
        n = (cols_cfg == 0) ? 1 : int'(cols_cfg);
        if (n > MAX_COLS_DEF)
            n = MAX_COLS_DEF;
        c = col_count % MAX_COLS_DEF;
        col_last = col_count >= n - 1;
        row_last = row_count >= m - 1;

        if (row_count == 0) begin
            if (row_last)
                queue_product(mul(dg, rhs), 0, c, col_last, 1'b1);
        end else begin
            acc = mul(held_diag, held_row[c]) + mul(held_upper, rhs);
            if (row_count >= 2)
                acc += mul(held_lower, older_row[c]);
            queue_product(acc, row_count - 1, c, 1'b0, !row_last);
            if (row_last)
                queue_product(mul(lo, held_row[c]) + mul(dg, rhs), row_count, c,
                              col_last, 1'b1);
        end

        older_row[c] = held_row[c];
        held_row[c]  = rhs;
        if (col_last) begin
            held_upper = up;
            held_diag  = dg;
            held_lower = lo;
            col_count  = 0;
            row_count  = row_last ? 0 : ((row_count + 1) & 32'hFFFF);
        end else begin
            col_count = col_count + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_product got;
        t_product want;
        if (!i_rst_n) begin
            products.delete();
            rows_cfg   = 1;
            cols_cfg   = 1;
            held_upper = '0;
            held_diag  = '0;
            held_lower = '0;
            col_count  = 0;
            row_count  = 0;
            fails      = 0;
            checked    = 0;
            for (int i = 0; i < MAX_COLS_DEF; i++) begin
                older_row[i] = '0;
                held_row[i]  = '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS: rows_cfg = i_cfg_data[CFG_ROWS_W-1:0];
                    REG_COLS: cols_cfg = i_cfg_data[CFG_COLS_W-1:0];
                    default: ;
                endcase
            end
            if (i_req.valid && i_req.ready)
                predict_products(i_req.rhs_value, i_req.upper_coef, i_req.diag_coef,
                                 i_req.lower_coef);
            if (o_rsp.valid && o_rsp.ready) begin
                got = '{value: o_rsp.out_value, row: o_rsp.out_row, col: o_rsp.out_col,
                        mlast: o_rsp.matrix_last, rlast: o_rsp.run_last};
                checked++;
                if (products.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result: expected none, got %s",
                             $time, describe(got));
                end else begin
                    want = products.pop_front();
                    if (got !== want) begin
                        fails++;
                        $display("%0t: mismatch: expected %s, got %s",
                                 $time, describe(want), describe(got));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= products.size();
        o_checked    <= checked;
    end

endmodule

// ===== bench/tridiagonal_matrix_multiply_stream_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Tridiagonal matrix multiply stream testbench
// Drives element requests with their row coefficients through a range of
// matrix sizes, stalls both channels at random, and lets the product checker
// compare every result against its own prediction.
// ============================================================================
module tridiagonal_matrix_multiply_stream_tb;
    import tdmm_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int ITEMS_TARGET  = 650;
    localparam int CALM_ITEMS    = 100;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_LIMIT   = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    tdmm_in_if  req_if ();
    tdmm_out_if rsp_if ();

    int fail_count;
    int pending;
    int checked;

    // Stimulus bookkeeping. calm turns idling off near the end of the run;
    // long_hold asks the result side for one long stall.
    int requests_sent;
    int phases;
    bit calm;
    bit long_hold;
    bit stuck;

    // Last sizes written, used only to shape whole matrices in the random part.
    int rows_set;
    int cols_set;

    tridiagonal_matrix_multiply_stream dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    tridiagonal_product_checker product_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_req        (req_if),
        .o_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Mostly random Q1.15 values, with the two extremes showing up often.
    function automatic int rand_q15();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // A register write ends with a trailing edge, which keeps the write
    // enable from being lowered and raised again in the same step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_ROWS)
            rows_set = value & 32'hFFFF;
        else
            cols_set = value & 32'h1FF;
    endtask

    // Offer one request, with an occasional random gap in front of it, and
    // return right after the edge at which it was accepted.
    task automatic offer(input int rhs, input int up, input int dg, input int lo);
        if (!calm && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.rhs_value  <= 16'(rhs);
        req_if.upper_coef <= 16'(up);
        req_if.diag_coef  <= 16'(dg);
        req_if.lower_coef <= 16'(lo);
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        requests_sent++;
    endtask

    task automatic offer_random();
        offer(rand_q15(), rand_q15(), rand_q15(), rand_q15());
    endtask

    // Stop offering, wait until every predicted product has come back, then
    // let a few more cycles pass: a request on a matrix's first row makes no
    // result, yet it may still be in the pipeline when the last result lands.
    task automatic settle(input int quiet);
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0)
            stuck = 1'b1;
        repeat (quiet) @(posedge i_clk);
    endtask

    // Result side: random ready bursts, one long stall on request, and a
    // steady ready once the run has gone calm.
    initial begin
        rsp_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("** tridiagonal_matrix_multiply_stream: FAILED **");
        $finish;
    end

    initial begin
        int rows_val;
        int cols_val;
        int m_eff;
        int n_eff;
        int count;

        requests_sent = 0;
        phases        = 0;
        calm          = 1'b0;
        long_hold     = 1'b0;
        stuck         = 1'b0;
        rows_set      = 1;
        cols_set      = 1;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_ROWS;
        i_cfg_data        <= '0;
        req_if.valid      <= 1'b0;
        req_if.rhs_value  <= '0;
        req_if.upper_coef <= '0;
        req_if.diag_coef  <= '0;
        req_if.lower_coef <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Reset sizes are one by one, so each request is a
        // single-row matrix and returns diag * rhs; the lower coefficient on
        // row zero must be ignored.
        offer(-32768, 0, -32768, 12345);
        offer(32767, 32767, -32768, 32767);
        offer(0, -1, -1, -1);
        offer(-1, 21845, 32767, -21846);
        settle(SETTLE_CYCLES);
        phases++;

        // A three by two matrix with extreme values. In its last column the middle
        // row sums three products of the same sign, which is the widest result; the
        // last row shows the two-result rule, the first row gives nothing.
        write_reg(REG_ROWS, 3);
        write_reg(REG_COLS, 2);
        offer(-32768, -32768, -32768, 32767);
        offer(-32768, -32768, -32768, 32767);
        offer(-32768, -32768, -32768, -32768);
        offer(-32768, -32768, -32768, -32768);
        offer(32767, 32767, 32767, 32767);
        offer(-32768, 32767, 32767, 32767);
        settle(SETTLE_CYCLES);
        phases++;

        // Zero sizes behave as one.
        write_reg(REG_ROWS, 0);
        write_reg(REG_COLS, 0);
        offer(12345, -1, 32767, -32768);
        offer(-32768, 32767, 32767, 32767);
        settle(SETTLE_CYCLES);
        phases++;

        // Stop a two by three matrix on row one, then shrink both sizes to
        // one. The column count is then past the last column and the row is
        // not row zero, so the next request still gives two results.
        write_reg(REG_ROWS, 2);
        write_reg(REG_COLS, 3);
        repeat (4) offer_random();
        settle(SETTLE_CYCLES);
        write_reg(REG_ROWS, 1);
        write_reg(REG_COLS, 1);
        repeat (3) offer_random();
        settle(SETTLE_CYCLES);
        phases++;

        // A full-width single-row matrix. The column register gets its
        // all-ones value, which clamps to the largest buffer. The result side
        // stalls for a long stretch at the start so the pipeline backs up,
        // and halfway through the request side waits for every result.
        write_reg(REG_ROWS, 1);
        write_reg(REG_COLS, 16'hFFFF);
        long_hold = 1'b1;
        for (int i = 0; i < MAX_COLS_DEF; i++) begin
            if (i == MAX_COLS_DEF / 2)
                settle(0);
            offer_random();
        end
        phases++;

        // Random part: mostly whole matrices of small sizes with random
        // content, some cut short so that the next size change lands
        // mid-matrix, and now and then the largest row count or column count.
        while (requests_sent < ITEMS_TARGET) begin
            settle(SETTLE_CYCLES);
            case ($urandom_range(0, 11))
                0: rows_val = 0;
                1: rows_val = 65535;
                2: rows_val = 1;
                default: rows_val = $urandom_range(2, 4);
            endcase
            case ($urandom_range(0, 11))
                0: cols_val = 0;
                1: cols_val = 256;
                default: cols_val = $urandom_range(1, 6);
            endcase
            // Upper data bits above the column field are junk on purpose.
            cols_val = cols_val | ($urandom_range(0, 127) << CFG_COLS_W);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_ROWS, rows_val);
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_COLS, cols_val);

            m_eff = (rows_set == 0) ? 1 : rows_set;
            n_eff = (cols_set == 0) ? 1 : ((cols_set > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_set);
            if (m_eff <= 4 && n_eff <= 8) begin
                count = m_eff * n_eff * $urandom_range(1, 3);
                if ($urandom_range(0, 4) == 0)
                    count = $urandom_range(1, count);
            end else begin
                count = $urandom_range(1, 24);
            end

            calm = (requests_sent >= ITEMS_TARGET - CALM_ITEMS);
            repeat (count) offer_random();
            phases++;
        end

        settle(SETTLE_CYCLES);

        $display("Summary: %0d requests in %0d sizing phases, %0d results checked.",
                 requests_sent, phases, checked);
        $display("Summary: one-row and tall matrices, odd sizes, long result stall.");
        if (fail_count == 0 && !stuck) begin
            $display("** tridiagonal_matrix_multiply_stream: PASSED **");
        end else begin
            $display("** tridiagonal_matrix_multiply_stream: FAILED **");
        end
        $finish;
    end

endmodule
